// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the frame receiver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLIES(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst, cond, prop, msg)

`define ASSERT_NEXT(label, clk, rst, cond, prop, msg)

`endif

`endif

// File: hw/rtl/ufrc_pkg.sv
// Types, constants and the CRC function of the framed byte receiver.
package ufrc_pkg;

   localparam int unsigned MAX_PAYLOAD_DEFAULT = 64;
   localparam int unsigned PAYLOAD_INDEX_W = 6;

   localparam logic [7:0] START_BYTE = 8'h55;
   localparam logic [7:0] STOP_BYTE = 8'h0D;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   typedef enum logic {
      MODE_BYTE = 1'b0,
      MODE_OVERRUN = 1'b1
   } mode_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_REPORT = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK = 2'd0,
      STATUS_CRC_ERROR = 2'd1,
      STATUS_STOP_ERROR = 2'd2,
      STATUS_LENGTH_ERROR = 2'd3
   } status_type;

   typedef struct packed {
      mode_type mode;
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      kind_type kind;
      logic [7:0] payload_byte;
      logic [PAYLOAD_INDEX_W-1:0] payload_index;
      logic [15:0] command_id;
      logic [15:0] data_length;
      status_type status;
   } rsp_payload_type;

   // Reflected CRC-16 over one byte, least significant bit first.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// File: hw/rtl/uart_frame_receiver_crc16.sv
// Top level of the framed byte receiver with CRC-16 check.
// The block takes one item per clock cycle while it is not stalled: a received byte or an
// overrun event. Frames are 0x55, command id, length, payload, CRC (high byte first) and
// 0x0D; the reflected CRC-16 (polynomial 0xA001, initial value 0) covers the start, id,
// length and payload bytes. Each payload byte leaves as an item of its own, and every frame
// that reaches its stop byte or carries a length above MAX_PAYLOAD ends with a report item.
// An item's result appears in the cycle after it is accepted, from the single result
// register; a new item is taken in every cycle in which that register is empty or being
// emptied, so the sustained rate is one item per cycle. Bytes outside a frame other than
// 0x55 are dropped, and an overrun event drops the current frame without a report.
`include "assert_macros.svh"

module uart_frame_receiver_crc16 #(
   parameter int unsigned MAX_PAYLOAD = ufrc_pkg::MAX_PAYLOAD_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input ufrc_pkg::req_payload_type req_data,
   output logic rsp_valid,
   input logic rsp_ready,
   output ufrc_pkg::rsp_payload_type rsp_data
);
   import ufrc_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_CMD_HI,
      PH_CMD_LO,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_PAYLOAD,
      PH_CRC_HI,
      PH_CRC_LO,
      PH_STOP
   } phase_type;

   phase_type phase_ff, phase_in;
   logic [15:0] cmd_ff, cmd_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] rcrc_ff, rcrc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic req_accept;
   logic emit;
   logic [7:0] rx;
   logic [15:0] crc_base;
   logic [15:0] crc_upd;
   logic [15:0] len_full;
   logic [CNT_W:0] cnt_sum;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign rx = req_data.rx_byte;
   assign crc_base = (phase_ff == PH_IDLE) ? 16'h0000 : crc_ff;
   assign crc_upd = crc_byte(crc_base, rx);
   assign len_full = {len_ff[15:8], rx};
   assign cnt_sum = {1'b0, cnt_ff} + {{CNT_W{1'b0}}, 1'b1};

   always_comb begin
      phase_in = phase_ff;
      cmd_in = cmd_ff;
      len_in = len_ff;
      crc_in = crc_ff;
      rcrc_in = rcrc_ff;
      cnt_in = cnt_ff;
      emit = 1'b0;
      rsp_data_in = '0;
      rsp_data_in.kind = KIND_REPORT;
      rsp_data_in.command_id = cmd_ff;
      rsp_data_in.data_length = len_ff;
      rsp_data_in.status = STATUS_OK;
      if (req_data.mode == MODE_OVERRUN) begin
         phase_in = PH_IDLE;
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               if (rx == START_BYTE) begin
                  phase_in = PH_CMD_HI;
                  cmd_in = '0;
                  len_in = '0;
                  rcrc_in = '0;
                  cnt_in = '0;
                  crc_in = crc_upd;
               end
            end
            PH_CMD_HI: begin
               cmd_in = {rx, 8'h00};
               crc_in = crc_upd;
               phase_in = PH_CMD_LO;
            end
            PH_CMD_LO: begin
               cmd_in = {cmd_ff[15:8], rx};
               crc_in = crc_upd;
               phase_in = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               len_in = {rx, 8'h00};
               crc_in = crc_upd;
               phase_in = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               len_in = len_full;
               crc_in = crc_upd;
               cnt_in = '0;
               if (32'(len_full) > 32'(MAX_PAYLOAD)) begin
                  phase_in = PH_IDLE;
                  emit = 1'b1;
                  rsp_data_in.data_length = len_full;
                  rsp_data_in.status = STATUS_LENGTH_ERROR;
               end else if (len_full == 16'h0000) begin
                  phase_in = PH_CRC_HI;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               crc_in = crc_upd;
               cnt_in = cnt_sum[CNT_W-1:0];
               emit = 1'b1;
               rsp_data_in = '0;
               rsp_data_in.kind = KIND_PAYLOAD;
               rsp_data_in.payload_byte = rx;
               rsp_data_in.payload_index = PAYLOAD_INDEX_W'(cnt_ff);
               rsp_data_in.status = STATUS_OK;
               if (32'(cnt_sum) >= 32'(len_ff)) begin
                  phase_in = PH_CRC_HI;
               end
            end
            PH_CRC_HI: begin
               rcrc_in = {rx, 8'h00};
               phase_in = PH_CRC_LO;
            end
            PH_CRC_LO: begin
               rcrc_in = {rcrc_ff[15:8], rx};
               phase_in = PH_STOP;
            end
            PH_STOP: begin
               emit = 1'b1;
               phase_in = PH_IDLE;
               if (rx != STOP_BYTE) begin
                  rsp_data_in.status = STATUS_STOP_ERROR;
               end else if (rcrc_ff != crc_ff) begin
                  rsp_data_in.status = STATUS_CRC_ERROR;
               end else begin
                  rsp_data_in.status = STATUS_OK;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            phase_ff <= phase_in;
            rsp_valid_ff <= emit;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff <= cmd_in;
         len_ff <= len_in;
         crc_ff <= crc_in;
         rcrc_ff <= rcrc_in;
         cnt_ff <= cnt_in;
         if (emit) begin
            rsp_data_ff <= rsp_data_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   `ASSERT_IMPLIES(a_ready_when_empty, clock, reset, !rsp_valid_ff, req_ready,
      "Input stalled although the result register is empty.")

   `ASSERT_NEXT(a_overrun_drops_frame, clock, reset,
      req_accept && req_data.mode == MODE_OVERRUN,
      phase_ff == PH_IDLE && !rsp_valid_ff, "Overrun event did not drop the frame.")

   `ASSERT_NEXT(a_payload_gives_item, clock, reset,
      req_accept && req_data.mode == MODE_BYTE && phase_ff == PH_PAYLOAD,
      rsp_valid_ff && rsp_data_ff.kind == KIND_PAYLOAD, "Payload byte produced no item.")

   `ASSERT_IMPLIES(a_payload_fields_clear, clock, reset,
      rsp_valid_ff && rsp_data_ff.kind == KIND_PAYLOAD,
      rsp_data_ff.status == STATUS_OK && rsp_data_ff.command_id == 16'h0000,
      "Payload item carries report fields.")

endmodule

// File: tb/sv/tb_uart_frame_receiver_crc16.sv
// Self-checking testbench for the framed byte receiver with CRC-16 check.
`timescale 1ns / 100ps

module tb_uart_frame_receiver_crc16;
   import ufrc_pkg::*;

   localparam int FRAME_DATA_LIMIT = MAX_PAYLOAD_DEFAULT;
   localparam int ITEMS_PER_PHASE = 450;
   localparam int MAX_PRINTED = 40;

   typedef enum logic [3:0] {
      FP_IDLE,
      FP_CMD_HI,
      FP_CMD_LO,
      FP_LEN_HI,
      FP_LEN_LO,
      FP_DATA,
      FP_CRC_HI,
      FP_CRC_LO,
      FP_STOP
   } frame_phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_data;

   req_payload_type pending_bytes[$];
   rsp_payload_type expected_frame_items[$];
   int mismatch_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   frame_phase_type rx_phase = FP_IDLE;
   logic [15:0] rx_command = '0;
   logic [15:0] rx_length = '0;
   logic [15:0] rx_crc_calc = '0;
   logic [15:0] rx_crc_field = '0;
   logic [15:0] rx_data_count = '0;

   uart_frame_receiver_crc16 dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] d);
      logic [15:0] r;
      r = acc;
      for (int k = 0; k < 8; k++) begin
         if (r[0] ^ d[k]) begin
            r = (r >> 1) ^ CRC_POLY;
         end else begin
            r = r >> 1;
         end
      end
      return r;
   endfunction

   function automatic void deframe_item(input req_payload_type it);
      rsp_payload_type r;
      logic [7:0] b;
      r = '0;
      b = it.rx_byte;
      if (it.mode == MODE_OVERRUN) begin
         rx_phase = FP_IDLE;
      end else begin
         case (rx_phase)
            FP_IDLE: begin
               if (b == START_BYTE) begin
                  rx_phase = FP_CMD_HI;
                  rx_command = '0;
                  rx_length = '0;
                  rx_crc_field = '0;
                  rx_data_count = '0;
                  rx_crc_calc = crc16_update(16'h0000, b);
               end
            end
            FP_CMD_HI: begin
               rx_command = {b, 8'h00};
               rx_crc_calc = crc16_update(rx_crc_calc, b);
               rx_phase = FP_CMD_LO;
            end
            FP_CMD_LO: begin
               rx_command[7:0] = b;
               rx_crc_calc = crc16_update(rx_crc_calc, b);
               rx_phase = FP_LEN_HI;
            end
            FP_LEN_HI: begin
               rx_length = {b, 8'h00};
               rx_crc_calc = crc16_update(rx_crc_calc, b);
               rx_phase = FP_LEN_LO;
            end
            FP_LEN_LO: begin
               rx_length[7:0] = b;
               rx_crc_calc = crc16_update(rx_crc_calc, b);
               if (rx_length > FRAME_DATA_LIMIT) begin
                  r.kind = KIND_REPORT;
                  r.command_id = rx_command;
                  r.data_length = rx_length;
                  r.status = STATUS_LENGTH_ERROR;
                  expected_frame_items.push_back(r);
                  rx_phase = FP_IDLE;
               end else begin
                  rx_data_count = '0;
                  rx_phase = (rx_length == 0) ? FP_CRC_HI : FP_DATA;
               end
            end
            FP_DATA: begin
               rx_crc_calc = crc16_update(rx_crc_calc, b);
               r.kind = KIND_PAYLOAD;
               r.payload_byte = b;
               r.payload_index = rx_data_count[PAYLOAD_INDEX_W-1:0];
               expected_frame_items.push_back(r);
               rx_data_count = rx_data_count + 16'd1;
               if (rx_data_count >= rx_length) begin
                  rx_phase = FP_CRC_HI;
               end
            end
            FP_CRC_HI: begin
               rx_crc_field = {b, 8'h00};
               rx_phase = FP_CRC_LO;
            end
            FP_CRC_LO: begin
               rx_crc_field[7:0] = b;
               rx_phase = FP_STOP;
            end
            FP_STOP: begin
               r.kind = KIND_REPORT;
               r.command_id = rx_command;
               r.data_length = rx_length;
               if (b != STOP_BYTE) begin
                  r.status = STATUS_STOP_ERROR;
               end else if (rx_crc_field != rx_crc_calc) begin
                  r.status = STATUS_CRC_ERROR;
               end else begin
                  r.status = STATUS_OK;
               end
               expected_frame_items.push_back(r);
               rx_phase = FP_IDLE;
            end
            default: begin
               rx_phase = FP_IDLE;
            end
         endcase
      end
   endfunction

   task automatic report_mismatch(input string field, input logic [15:0] got,
                                  input logic [15:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED) begin
         $display("ERROR at %0t: %s is 0x%0h, expected 0x%0h", $time, field, got, want);
      end
   endtask

   task automatic check_frame_item(input rsp_payload_type got);
      rsp_payload_type want;
      if (expected_frame_items.size() == 0) begin
         report_mismatch("item with none awaited, kind", 16'(got.kind), '0);
      end else begin
         want = expected_frame_items.pop_front();
         if (got.kind !== want.kind) begin
            report_mismatch("kind", 16'(got.kind), 16'(want.kind));
         end
         if (got.payload_byte !== want.payload_byte) begin
            report_mismatch("payload_byte", 16'(got.payload_byte), 16'(want.payload_byte));
         end
         if (got.payload_index !== want.payload_index) begin
            report_mismatch("payload_index", 16'(got.payload_index),
                            16'(want.payload_index));
         end
         if (got.command_id !== want.command_id) begin
            report_mismatch("command_id", got.command_id, want.command_id);
         end
         if (got.data_length !== want.data_length) begin
            report_mismatch("data_length", got.data_length, want.data_length);
         end
         if (got.status !== want.status) begin
            report_mismatch("status", 16'(got.status), 16'(want.status));
         end
      end
   endtask

   function automatic void push_rx_byte(input logic [7:0] b);
      req_payload_type it;
      it.mode = MODE_BYTE;
      it.rx_byte = b;
      pending_bytes.push_back(it);
   endfunction

   function automatic void push_overrun();
      req_payload_type it;
      it.mode = MODE_OVERRUN;
      it.rx_byte = 8'($urandom_range(0, 255));
      pending_bytes.push_back(it);
   endfunction

   // Queues one frame and returns the number of items it took.
   function automatic int queue_frame(input logic [15:0] cmd, input logic [15:0] len,
                                      input bit crc_fault, input bit stop_fault,
                                      input bit abort);
      logic [7:0] frame_bytes[$];
      logic [15:0] crc;
      logic [7:0] stop;
      int cut;
      frame_bytes = '{START_BYTE, cmd[15:8], cmd[7:0], len[15:8], len[7:0]};
      if (len <= FRAME_DATA_LIMIT) begin
         for (int i = 0; i < len; i++) begin
            frame_bytes.push_back(8'($urandom_range(0, 255)));
         end
         crc = 16'h0000;
         foreach (frame_bytes[i]) begin
            crc = crc16_update(crc, frame_bytes[i]);
         end
         if (crc_fault) begin
            crc = crc ^ 16'($urandom_range(1, 65535));
         end
         stop = stop_fault ? (STOP_BYTE ^ 8'($urandom_range(1, 255))) : STOP_BYTE;
         frame_bytes.push_back(crc[15:8]);
         frame_bytes.push_back(crc[7:0]);
         frame_bytes.push_back(stop);
      end
      cut = abort ? $urandom_range(1, frame_bytes.size() - 1) : frame_bytes.size();
      for (int i = 0; i < cut; i++) begin
         push_rx_byte(frame_bytes[i]);
      end
      if (abort) begin
         push_overrun();
      end
      return abort ? cut + 1 : cut;
   endfunction

   // Line noise, always closed by an overrun so that the next frame starts clean.
   function automatic void queue_noise();
      int n;
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 3) == 0) begin
            push_overrun();
         end else if ($urandom_range(0, 4) == 0) begin
            push_rx_byte(START_BYTE);
         end else begin
            push_rx_byte(8'($urandom_range(0, 255)));
         end
      end
      push_overrun();
   endfunction

   function automatic logic [15:0] pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 16'($urandom_range(0, 8));
      end else if (r < 80) begin
         return 16'($urandom_range(9, FRAME_DATA_LIMIT - 1));
      end else if (r < 88) begin
         return 16'(FRAME_DATA_LIMIT);
      end else if (r < 94) begin
         return 16'(FRAME_DATA_LIMIT + 1);
      end else begin
         return 16'($urandom_range(FRAME_DATA_LIMIT + 2, 65535));
      end
   endfunction

   task automatic wait_drained();
      while (pending_bytes.size() != 0 || req_valid || expected_frame_items.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            deframe_item(req_data);
         end
         if (!req_valid || req_ready) begin
            if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= pending_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_frame_item(rsp_data);
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   initial begin
      #20_000_000;
      $display("uart_frame_receiver_crc16: mismatch");
      $finish;
   end

   initial begin
      int send_pcts[4];
      int stall_pcts[4];
      int taken;
      send_pcts = '{0, 67, 0, 28};
      stall_pcts = '{0, 0, 67, 28};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      push_rx_byte(8'h00);
      push_overrun();
      void'(queue_frame(16'hFFFF, 16'd0, 1'b0, 1'b0, 1'b0));
      void'(queue_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b0));
      void'(queue_frame(16'h5555, 16'd1, 1'b1, 1'b0, 1'b0));
      void'(queue_frame(16'h1234, 16'd8, 1'b0, 1'b0, 1'b1));
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = send_pcts[p];
         recv_stall_pct = stall_pcts[p];
         taken = 0;
         while (taken < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 99) < 85) begin
               taken += queue_frame(16'($urandom_range(0, 65535)), pick_length(),
                                    $urandom_range(0, 99) < 12,
                                    $urandom_range(0, 99) < 12,
                                    $urandom_range(0, 99) < 8);
            end else begin
               queue_noise();
            end
         end
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("uart_frame_receiver_crc16: match");
      end else begin
         $display("uart_frame_receiver_crc16: mismatch");
      end
      $finish;
   end

endmodule

// File: uart_frame_receiver_crc16.f
+incdir+hw/rtl
hw/rtl/ufrc_pkg.sv
hw/rtl/uart_frame_receiver_crc16.sv
tb/sv/tb_uart_frame_receiver_crc16.sv
